// ----- rtl/core/fpcm_pkg.sv -----
// Package for the float-to-PCM converter: beat payload types, format codes
// and the scale constants for each output format. No dependencies.
package fpcm_pkg;

  // Output format codes held in the configuration register.
  typedef enum logic [1:0] {
    FMT_S32 = 2'd0,
    FMT_S24 = 2'd1,
    FMT_S16 = 2'd2,
    FMT_RSV = 2'd3
  } fmt_t;

  localparam int FmtWidth = 2;

  // Positive limits of each format.
  localparam logic signed [31:0] LimS32 = 32'sd2147483647;
  localparam logic signed [31:0] LimS24 = 32'sd16777215;
  localparam logic signed [31:0] LimS16 = 32'sd32767;

  // Scales normalized into [2^23, 2^24) with their binary exponent offset.
  localparam logic [23:0] ScaleS32 = 24'h800000;   // 2^31 = 2^23 * 2^8
  localparam logic [23:0] ScaleS24 = 24'hFFFFFF;   // 2^24 - 1
  localparam logic [23:0] ScaleS16 = 24'hFFFE00;   // 32767 * 2^9

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pcm_value;
    logic               end_of_buffer_out;
  } out_beat_t;

endpackage

// ----- rtl/core/float_to_pcm_saturating_converter_top.sv -----
// Float-to-PCM converter, top level: input register, one combinational
// conversion pass, result register. Depends on fpcm_pkg.
// An accepted beat goes from the input register to the result register.
// Throughput: one beat per cycle while not stalled; the single 24x24 product
// sets the path. Reset (synchronous, rst_n low) clears both valid flags and
// sets the format register to signed 32-bit.
module float_to_pcm_saturating_converter_top
  import fpcm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_beat_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_beat_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [FmtWidth-1:0] cfg_wr_data
);

  logic      s1_valid_r;
  in_beat_t  s1_data_r;
  logic      out_valid_r;
  out_beat_t out_data_r;
  out_beat_t out_data_nxt;
  fmt_t      fmt_r;
  logic      advance;
  logic      s1_load;

  // The result register moves whenever it is free or drained; the input
  // register also fills whenever it is empty.
  assign advance  = !out_valid_r || !out_stall;
  assign s1_load  = advance || !s1_valid_r;
  assign in_stall = !s1_load;

  // Field decode of the registered sample.
  logic        sgn;
  logic [7:0]  exp_f;
  logic [22:0] frac;
  logic [23:0] mant;
  logic [23:0] scale;
  logic signed [4:0]  scale_off;
  logic signed [31:0] lim;
  logic [47:0] prod;
  logic [23:0] rmant;
  logic        guard;
  logic        sticky;
  logic [24:0] rnd;
  logic signed [10:0] shamt;
  logic [10:0] nshamt;
  logic [33:0] mag;
  logic        is_nan;
  logic        over_one;

  always_comb begin
    sgn   = s1_data_r.sample_bits[31];
    exp_f = s1_data_r.sample_bits[30:23];
    frac  = s1_data_r.sample_bits[22:0];
    mant  = {1'b1, frac};

    case (fmt_r)
      FMT_S32: begin
        scale = ScaleS32; scale_off = 5'sd8;  lim = LimS32;
      end
      FMT_S24: begin
        scale = ScaleS24; scale_off = 5'sd0;  lim = LimS24;
      end
      default: begin
        scale = ScaleS16; scale_off = -5'sd9; lim = LimS16;
      end
    endcase

    // Product normalized to 24 bits, rounded to nearest even.
    prod = mant * scale;
    if (prod[47]) begin
      rmant  = prod[47:24];
      guard  = prod[23];
      sticky = |prod[22:0];
    end else begin
      rmant  = prod[46:23];
      guard  = prod[22];
      sticky = |prod[21:0];
    end
    rnd = {1'b0, rmant} + {24'd0, guard && (sticky || rmant[0])};

    // Binary point position of the rounded mantissa.
    shamt = $signed({3'b000, exp_f}) + (prod[47] ? 11'sd24 : 11'sd23)
            - 11'sd150 + 11'(scale_off);
    nshamt = 11'(-shamt);
    if (!shamt[10]) begin
      mag = {9'd0, rnd} << shamt[3:0];
    end else if (nshamt > 11'd24) begin
      mag = '0;
    end else begin
      mag = {9'd0, rnd >> nshamt[4:0]};
    end

    is_nan   = (exp_f == 8'hFF) && (frac != '0);
    over_one = (exp_f > 8'd127) || ((exp_f == 8'd127) && (frac != '0));

    // Special cases first, then saturation of the magnitude to the 32-bit range.
    // Zero and subnormal inputs scale to less than one.
    if (is_nan) begin
      out_data_nxt.pcm_value = '0;
    end else if (over_one) begin
      out_data_nxt.pcm_value = sgn ? -lim : lim;
    end else if (exp_f == 8'd0) begin
      out_data_nxt.pcm_value = '0;
    end else if (mag[33:31] != 3'd0) begin
      out_data_nxt.pcm_value = sgn ? 32'sh80000000 : LimS32;
    end else begin
      out_data_nxt.pcm_value = sgn ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    end
    out_data_nxt.end_of_buffer_out = s1_data_r.end_of_buffer;
  end

  // Control registers and the format register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fmt_r       <= FMT_S32;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_wr_en) begin
        fmt_r <= fmt_t'(cfg_wr_data);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/fpcm_checker.sv -----
// Port-level checker for the float-to-PCM converter, bound to the top level.
// Depends on fpcm_pkg.
module fpcm_checker
  import fpcm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // A stalled result beat holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Reset empties the result side.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input stalls only when the result side is full and stalled.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

  // An accepted beat with no downstream stall moves on to the result register.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted beat lost");

endmodule

bind float_to_pcm_saturating_converter_top fpcm_checker u_fpcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/sv/float_to_pcm_saturating_converter_top_tb.sv -----
// Testbench for the float-to-PCM saturating converter. Drives float32 sample
// beats, predicts each PCM result in integer arithmetic and checks the output.
// Depends on fpcm_pkg and float_to_pcm_saturating_converter_top.
module float_to_pcm_saturating_converter_top_tb;
  import fpcm_pkg::*;

  localparam int CycleLimit = 400000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_beat_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_beat_t           out_data;
  logic                cfg_wr_en;
  logic [FmtWidth-1:0] cfg_wr_data;

  // Predictor state and scoreboard.
  fmt_t      cur_format;
  out_beat_t pcm_expected[$];
  int        mismatch_count;
  int        cycle_count;
  int        hold_request;
  bit        idle_enabled;

  float_to_pcm_saturating_converter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on total run length.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Expected PCM value: exact product, rounded to 24 bits nearest-even,
  // then truncated toward zero and clamped to the 32-bit range.
  function automatic out_beat_t pcm_of_sample(in_beat_t b, fmt_t f);
    logic              sgn;
    int                e;
    logic [22:0]       frac;
    longint unsigned   sc;
    longint unsigned   p;
    longint unsigned   kept;
    longint unsigned   rem;
    longint unsigned   half;
    longint unsigned   mag;
    int                n;
    int                s;
    int                sh;
    logic signed [31:0] lim;
    out_beat_t         r;
    case (f)
      FMT_S32: begin
        sc  = 64'd2147483648;
        lim = LimS32;
      end
      FMT_S24: begin
        sc  = 64'd16777215;
        lim = LimS24;
      end
      default: begin
        sc  = 64'd32767;
        lim = LimS16;
      end
    endcase
    r.end_of_buffer_out = b.end_of_buffer;
    sgn  = b.sample_bits[31];
    e    = int'(b.sample_bits[30:23]);
    frac = b.sample_bits[22:0];
    // NaN gives zero.
    if (e == 255 && frac != 0) begin
      r.pcm_value = 0;
      return r;
    end
    // Magnitude above one, infinities included, saturates to the format limit.
    if (e > 127 || (e == 127 && frac != 0)) begin
      r.pcm_value = sgn ? -lim : lim;
      return r;
    end
    // Zero and subnormals scale to less than one.
    if (e == 0) begin
      r.pcm_value = 0;
      return r;
    end
    p = {40'd0, 1'b1, frac} * sc;
    n = 63;
    while (!p[n]) n--;
    kept = p;
    s = 0;
    if (n > 23) begin
      s    = n - 23;
      kept = p >> s;
      rem  = p & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && kept[0])) kept++;
    end
    sh = s + e - 150;
    if (sh >= 0) mag = kept << sh;
    else if (-sh >= 64) mag = 0;
    else mag = kept >> (-sh);
    if (mag >= 64'd2147483648) r.pcm_value = sgn ? 32'h80000000 : 32'h7FFFFFFF;
    else r.pcm_value = sgn ? -mag[31:0] : mag[31:0];
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one sample beat; valid stays high between back-to-back beats.
  task automatic send_sample(logic [31:0] bits, logic eob);
    int  gap;
    bit  st;
    in_beat_t b;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    b.sample_bits   = bits;
    b.end_of_buffer = eob;
    in_valid <= 1'b1;
    in_data  <= b;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    pcm_expected.push_back(pcm_of_sample(b, cur_format));
  endtask

  // Drop valid at once so the last beat is not offered again.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pcm_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Format register is written only with the pipeline empty.
  task automatic write_format(fmt_t f);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= f;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_format = f;
  endtask

  // Random sample, mostly with exponent 100 to 127, with a share of arbitrary bit patterns.
  function automatic logic [31:0] random_sample();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) != 0) v[30:23] = 8'($urandom_range(100, 127));
    if ($urandom_range(0, 15) == 0) v[22:0] = ($urandom_range(0, 1) != 0) ? '1 : '0;
    return v;
  endfunction

  task automatic test_edge_values(fmt_t f);
    logic [31:0] vals[$];
    write_format(f);
    vals = '{32'h3F800000, 32'hBF800000, 32'h00000000, 32'h80000000,
             32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFFFFFFFF,
             32'h3F800001, 32'hBF800001, 32'h3F7FFFFF, 32'hBF7FFFFF,
             32'h00000001, 32'h807FFFFF, 32'h3F000000, 32'h38000000,
             32'h33800000, 32'h7F7FFFFF};
    foreach (vals[i]) send_sample(vals[i], i[0]);
  endtask

  task automatic test_random_stream(fmt_t f, int count);
    write_format(f);
    repeat (count) send_sample(random_sample(), 1'($urandom_range(0, 1)));
  endtask

  // Back-to-back beats with no idling on either side.
  task automatic test_full_rate(int count);
    idle_enabled = 1'b0;
    repeat (count) send_sample(random_sample(), 1'($urandom_range(0, 1)));
    wait_drained();
    idle_enabled = 1'b1;
  endtask

  // Receiver holds off long enough that the input side stalls.
  task automatic test_output_backpressure(int count);
    hold_request = 200;
    repeat (count) send_sample(random_sample(), 1'($urandom_range(0, 1)));
  endtask

  // Receiver stall generation.
  initial begin
    int hold;
    int r;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if (!idle_enabled) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) out_stall <= 1'b0;
        else begin
          out_stall <= 1'b1;
          hold = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  // Result checker: sample before the edge, compare beats accepted at it.
  initial begin
    out_beat_t got;
    out_beat_t want;
    bit        take;
    forever begin
      @(negedge clk);
      take = rst_n && out_valid && !out_stall;
      got  = out_data;
      @(posedge clk);
      if (take) begin
        if (pcm_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected beat: pcm %0d eob %0b", got.pcm_value,
                     got.end_of_buffer_out);
        end else begin
          want = pcm_expected.pop_front();
          if (got.pcm_value !== want.pcm_value ||
              got.end_of_buffer_out !== want.end_of_buffer_out) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected pcm %0d eob %0b, got pcm %0d eob %0b",
                       want.pcm_value, want.end_of_buffer_out,
                       got.pcm_value, got.end_of_buffer_out);
          end
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    cur_format     = FMT_S32;
    mismatch_count = 0;
    hold_request   = 0;
    idle_enabled   = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values(FMT_S32);
    test_edge_values(FMT_S16);
    test_random_stream(FMT_S32, 400);
    test_full_rate(100);
    test_random_stream(FMT_S24, 400);
    test_output_backpressure(100);
    test_random_stream(FMT_S16, 350);
    test_random_stream(FMT_RSV, 150);
    test_edge_values(FMT_S24);
    test_random_stream(FMT_S32, 100);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pcm_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/fpcm_pkg.sv
rtl/core/float_to_pcm_saturating_converter_top.sv
rtl/core/fpcm_checker.sv
tb/sv/float_to_pcm_saturating_converter_top_tb.sv
